[hw/rtl/assert_macros.svh]
// Assertion helpers used by the timer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define MDT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition that must never be true outside of reset.
`define MDT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/mdt_pkg.sv]
`timescale 1ns / 1ps

package mdt_pkg;

  // Bank size and result limits.
  localparam int SlotCount = 8;
  localparam int MaxResults = 8;
  localparam int SlotIdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam logic [30:0] DefaultInterval = 31'd1000;

  // Command codes.
  localparam logic [2:0] CmdTick = 3'd0;
  localparam logic [2:0] CmdConfig = 3'd1;
  localparam logic [2:0] CmdStart = 3'd2;
  localparam logic [2:0] CmdStop = 3'd3;
  localparam logic [2:0] CmdService = 3'd4;

  // Priority codes.
  localparam logic [1:0] PrioLow = 2'd0;
  localparam logic [1:0] PrioNormal = 2'd1;
  localparam logic [1:0] PrioHigh = 2'd2;

  // Fire kinds.
  localparam logic KindImmediate = 1'b0;
  localparam logic KindDeferred = 1'b1;

  // Direct write to one slot cell.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CONFIG,
    WR_START,
    WR_STOP
  } wr_op_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [31:0] now;
    logic [30:0] interval_ms;
    logic        auto_reload;
    logic [1:0]  priority_level;
    logic        handler_attached;
  } in_item_t;

  typedef struct packed {
    logic [2:0] fired_slot;
    logic       fire_kind;
    logic       last;
  } out_item_t;

  // State of one timer slot.
  typedef struct packed {
    logic [31:0] deadline;
    logic [30:0] interval;
    logic        reload;
    logic [1:0]  prio;
    logic        handler;
    logic        pending;
  } slot_rec_t;

  // Scan control handed to the head evaluator.
  typedef struct packed {
    logic service;
    logic room;
    logic halt;
  } head_ctrl_t;

endpackage

[hw/rtl/mdt_cell.sv]
`timescale 1ns / 1ps

module mdt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_en_i,
  input  mdt_pkg::slot_rec_t shift_rec_i,
  input  mdt_pkg::wr_op_e   op_i,
  input  mdt_pkg::in_item_t item_i,
  output mdt_pkg::slot_rec_t rec_o
);
  import mdt_pkg::*;

  slot_rec_t rec_q, rec_d;

  // Next record: take the neighbor during a scan, else apply a direct write.
  always_comb begin
    rec_d = rec_q;
    if (shift_en_i) begin
      rec_d = shift_rec_i;
    end else begin
      unique case (op_i)
        WR_CONFIG: begin
          rec_d.interval = item_i.interval_ms;
          rec_d.reload   = item_i.auto_reload;
          rec_d.prio     = item_i.priority_level;
          rec_d.handler  = item_i.handler_attached;
        end
        WR_START: rec_d.deadline = item_i.now + {1'b0, rec_q.interval};
        WR_STOP:  rec_d.deadline = '0;
        default:  rec_d = rec_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q.deadline <= '0;
      rec_q.interval <= DefaultInterval;
      rec_q.reload   <= 1'b0;
      rec_q.prio     <= PrioNormal;
      rec_q.handler  <= 1'b0;
      rec_q.pending  <= 1'b0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

[hw/rtl/mdt_head.sv]
`timescale 1ns / 1ps

module mdt_head (
  input  mdt_pkg::slot_rec_t  rec_i,
  input  logic [31:0]         now_i,
  input  mdt_pkg::head_ctrl_t ctrl_i,
  output mdt_pkg::slot_rec_t  rec_o,
  output logic                emit_o,
  output logic                halt_hit_o
);
  import mdt_pkg::*;

  logic due;

  // A running slot with a handler is due once its deadline is reached.
  assign due = (rec_i.deadline != '0) && rec_i.handler && (rec_i.deadline <= now_i);

  always_comb begin
    rec_o      = rec_i;
    emit_o     = 1'b0;
    halt_hit_o = 1'b0;
    if (!ctrl_i.service) begin
      // Tick: a due slot fires (high) or is marked pending (normal), then rearms or stops.
      if (due) begin
        if (rec_i.prio == PrioHigh) begin
          emit_o = ctrl_i.room;
        end else if (rec_i.prio == PrioNormal) begin
          rec_o.pending = 1'b1;
        end
        rec_o.deadline = rec_i.reload ? (rec_i.deadline + {1'b0, rec_i.interval}) : '0;
      end
    end else if (!ctrl_i.halt && rec_i.prio == PrioNormal && rec_i.pending) begin
      // Service: deliver deferred fires until the result limit is hit.
      if (!rec_i.handler) begin
        rec_o.pending = 1'b0;
      end else if (ctrl_i.room) begin
        emit_o        = 1'b1;
        rec_o.pending = 1'b0;
      end else begin
        halt_hit_o = 1'b1;
      end
    end
  end

endmodule

[hw/rtl/multi_channel_deadline_timer.sv]
`timescale 1ns / 1ps
// Configure, start and stop items cause no result.
// Tick and service items rotate the slot ring once, one slot per cycle while the
// output is not stalled. Each item is loaded, then the ring is rotated, then the
// held final event is flushed.
// Reset is asynchronous and active low: all slots stopped, interval 1000.
`include "assert_macros.svh"

module multi_channel_deadline_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mdt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mdt_pkg::out_item_t out_item_o
);
  import mdt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic                svc_q;
  logic [31:0]         now_q;
  logic [SlotIdxW-1:0] idx_q;
  logic [CntW-1:0]     cnt_q;
  logic                halt_q;
  logic                held_valid_q;
  logic [2:0]          held_slot_q;
  logic                held_kind_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  slot_rec_t  cell_rec [SlotCount];
  slot_rec_t  head_rec;
  head_ctrl_t head_ctrl;
  logic       emit, halt_hit;
  logic       accept, out_free, step, push_mid, push_end, scan_cmd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_cmd   = (in_item_i.cmd == CmdTick) || (in_item_i.cmd == CmdService);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = (state_q == ST_SCAN) && out_free;

  // Ring of slot cells; the head record returns to the tail after evaluation.
  for (genvar i = 0; i < SlotCount; i++) begin : g_cell
    slot_rec_t shift_in;
    wr_op_e    op;

    if (i == SlotCount - 1) begin : g_tail
      assign shift_in = head_rec;
    end else begin : g_mid
      assign shift_in = cell_rec[i+1];
    end

    always_comb begin
      op = WR_NONE;
      if (accept && (32'(in_item_i.slot) == i)) begin
        unique case (in_item_i.cmd)
          CmdConfig: op = WR_CONFIG;
          CmdStart:  op = WR_START;
          CmdStop:   op = WR_STOP;
          default:   op = WR_NONE;
        endcase
      end
    end

    mdt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (step),
      .shift_rec_i(shift_in),
      .op_i       (op),
      .item_i     (in_item_i),
      .rec_o      (cell_rec[i])
    );
  end

  // Evaluation of the slot at the head of the ring.
  assign head_ctrl.service = svc_q;
  assign head_ctrl.room    = (cnt_q < CntW'(MaxResults));
  assign head_ctrl.halt    = halt_q;

  mdt_head u_head (
    .rec_i     (cell_rec[0]),
    .now_i     (now_q),
    .ctrl_i    (head_ctrl),
    .rec_o     (head_rec),
    .emit_o    (emit),
    .halt_hit_o(halt_hit)
  );

  // One event is held back so the final one can be marked.
  assign push_mid = step && emit && held_valid_q;
  assign push_end = (state_q == ST_FLUSH) && held_valid_q && out_free;

  // Sequencer, held event and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      svc_q        <= 1'b0;
      now_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      halt_q       <= 1'b0;
      held_valid_q <= 1'b0;
      held_slot_q  <= '0;
      held_kind_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
    end else begin
      if (push_mid || push_end) begin
        out_valid_q           <= 1'b1;
        out_item_q.fired_slot <= held_slot_q;
        out_item_q.fire_kind  <= held_kind_q;
        out_item_q.last       <= push_end;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && scan_cmd) begin
            svc_q        <= (in_item_i.cmd == CmdService);
            now_q        <= in_item_i.now;
            idx_q        <= '0;
            cnt_q        <= '0;
            halt_q       <= 1'b0;
            held_valid_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (emit) begin
              held_valid_q <= 1'b1;
              held_slot_q  <= 3'(idx_q);
              held_kind_q  <= svc_q ? KindDeferred : KindImmediate;
              cnt_q        <= cnt_q + 1'b1;
            end
            if (halt_hit) begin
              halt_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
            if (idx_q == SlotIdxW'(SlotCount - 1)) begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!held_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            held_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks on the sequencer.
  `MDT_ASSERT(a_cnt_limit, clk_i, rst_ni, cnt_q <= CntW'(MaxResults), "event count over limit")
  `MDT_ASSERT_NEVER(a_held_idle, clk_i, rst_ni, (state_q == ST_IDLE) && held_valid_q, "held event left in idle")
  `MDT_ASSERT(a_scan_busy, clk_i, rst_ni, accept && scan_cmd |=> in_stall_o, "scan item not blocking input")

endmodule
